// ===== hw/rtl/abnf_pkg.sv =====
// Package for the ABNF rule tokenizer: codes, state and result types,
// and the per-character lexer step. No dependencies.
package abnf_pkg;

  localparam int MaxRes = 8;
  localparam logic [31:0] NumCap = 32'h7fff_ffff;

  // Token kinds.
  localparam logic [3:0] K_ALT = 4'd0, K_SOPEN = 4'd1, K_SCLOSE = 4'd2, K_OOPEN = 4'd3,
    K_OCLOSE = 4'd4, K_STR = 4'd5, K_NUM = 4'd6, K_RANGE = 4'd7, K_REP = 4'd8,
    K_IDENT = 4'd9, K_ERR = 4'd10;

  // Result parts.
  localparam logic [1:0] P_START = 2'd0, P_TEXT = 2'd1, P_NUM = 2'd2, P_END = 2'd3;

  // Lexer modes.
  localparam logic [3:0] M_IDLE = 4'd0, M_STRING = 4'd1, M_ESCAPE = 4'd2, M_PCT = 4'd3,
    M_FLAG = 4'd4, M_BASE1 = 4'd5, M_NUM = 4'd6, M_RANGE = 4'd7, M_IDENT = 4'd8,
    M_REP = 4'd9, M_COMMENT = 4'd10;

  // Error codes.
  localparam logic [3:0] E_BAD_START = 4'd0, E_END_PCT = 4'd1, E_BAD_DIGIT = 4'd2,
    E_FLAG = 4'd3, E_AFTER_PCT = 4'd4, E_EMPTY_GROUP = 4'd5, E_STAR2 = 4'd6,
    E_UNTERM = 4'd7, E_NEG_RANGE = 4'd8, E_EMPTY_RULE = 4'd9, E_OVERFLOW = 4'd10;

  // Number bases.
  localparam logic [1:0] B_BIN = 2'd0, B_DEC = 2'd1, B_HEX = 2'd2;

  localparam logic [7:0] C_PCT = 8'h25, C_SEMI = 8'h3b, C_STAR = 8'h2a, C_DASH = 8'h2d,
    C_DOT = 8'h2e, C_SPACE = 8'h20, C_QUOTE = 8'h22, C_BSLASH = 8'h5c, C_LT = 8'h3c,
    C_GT = 8'h3e, C_SLASH = 8'h2f, C_LPAR = 8'h28, C_RPAR = 8'h29, C_LBRK = 8'h5b,
    C_RBRK = 8'h5d, C_UNDER = 8'h5f;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  base;
    logic [31:0] acc;
    logic [31:0] lo;
    logic        gempty;
    logic        star;
    logic        sflag;
    logic [15:0] tstart;
    logic [15:0] tlen;
    logic [15:0] pos;
    logic        any;
    logic        failed;
  } state_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [1:0]  part;
    logic [7:0]  text_char;
    logic [31:0] number;
    logic        infinite;
    logic        case_sensitive;
    logic [15:0] start_pos;
    logic [15:0] span_len;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  typedef res_t [MaxRes-1:0] res_arr_t;

  function automatic state_t reset_state();
    state_t s;
    s = '0;
    s.mode = M_IDLE;
    s.gempty = 1'b1;
    return s;
  endfunction

  function automatic void emit(inout state_t s, inout res_arr_t r, inout logic [3:0] n,
                               input logic [3:0] kind, input logic [1:0] part,
                               input logic [7:0] ch, input logic [31:0] num,
                               input logic inf, input logic [15:0] st,
                               input logic [15:0] ln, input logic [3:0] err);
    if (n < 4'(MaxRes)) begin
      r[n[2:0]].token_kind = kind;
      r[n[2:0]].part = part;
      r[n[2:0]].text_char = ch;
      r[n[2:0]].number = num;
      r[n[2:0]].infinite = inf;
      r[n[2:0]].case_sensitive = (kind == K_STR) && s.sflag;
      r[n[2:0]].start_pos = st;
      r[n[2:0]].span_len = ln;
      r[n[2:0]].error_code = err;
      r[n[2:0]].last = 1'b0;
      n = n + 4'd1;
      if (kind != K_ERR) s.any = 1'b1;
    end
  endfunction

  function automatic void fail(inout state_t s, inout res_arr_t r, inout logic [3:0] n,
                               input logic [3:0] code, input logic [15:0] st,
                               input logic [15:0] ln);
    emit(s, r, n, K_ERR, P_END, 8'd0, 32'd0, 1'b0, st, ln, code);
    s.failed = 1'b1;
    s.mode = M_IDLE;
  endfunction

  function automatic void tok(inout state_t s, inout res_arr_t r, inout logic [3:0] n,
                              input logic [3:0] kind, input logic [1:0] part,
                              input logic [7:0] ch, input logic [31:0] num,
                              input logic inf);
    emit(s, r, n, kind, part, ch, num, inf, s.tstart, (part == P_END) ? s.tlen : 16'd0,
         4'd0);
  endfunction

  // Bit 4 set means the character is no digit of the base.
  function automatic logic [4:0] digval(input logic [1:0] base, input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (base == B_BIN) begin
      if (c == "0" || c == "1") v = {1'b0, c[3:0]};
    end else if (c >= "0" && c <= "9") begin
      v = {1'b0, c[3:0]};
    end else if (base != B_DEC) begin
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) v = 5'(c[2:0]) + 5'd9;
    end
    return v;
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void accumulate(inout state_t s, inout res_arr_t r, inout logic [3:0] n,
                                     input logic [3:0] d, input logic [15:0] pos);
    logic [35:0] prod;
    case (s.base)
      B_BIN:   prod = {3'd0, s.acc, 1'b0};
      B_DEC:   prod = {1'b0, s.acc, 3'd0} + {3'd0, s.acc, 1'b0};
      default: prod = {s.acc, 4'd0};
    endcase
    prod = prod + 36'(d);
    if (prod > 36'(NumCap)) begin
      fail(s, r, n, E_OVERFLOW, pos, 16'd1);
    end else begin
      s.acc = prod[31:0];
      s.gempty = 1'b0;
      s.tlen = s.tlen + 16'd1;
    end
  endfunction

  function automatic void close_token(inout state_t s, inout res_arr_t r,
                                      inout logic [3:0] n, input logic [15:0] pos,
                                      input logic at_end);
    logic [3:0] m;
    m = s.mode;
    s.mode = M_IDLE;
    if ((m == M_NUM || m == M_RANGE) && s.gempty) begin
      if (at_end) fail(s, r, n, E_UNTERM, s.tstart, s.tlen);
      else fail(s, r, n, E_EMPTY_GROUP, pos, 16'd1);
    end else if (m == M_NUM) begin
      if (!s.star) tok(s, r, n, K_NUM, P_START, 8'd0, 32'd0, 1'b0);
      tok(s, r, n, K_NUM, P_NUM, 8'd0, s.acc, 1'b0);
      tok(s, r, n, K_NUM, P_END, 8'd0, 32'd0, 1'b0);
    end else if (m == M_RANGE) begin
      if (s.acc <= s.lo) begin
        fail(s, r, n, E_NEG_RANGE, s.tstart, s.tlen);
      end else begin
        tok(s, r, n, K_RANGE, P_START, 8'd0, 32'd0, 1'b0);
        tok(s, r, n, K_RANGE, P_NUM, 8'd0, s.lo, 1'b0);
        tok(s, r, n, K_RANGE, P_NUM, 8'd0, s.acc, 1'b0);
        tok(s, r, n, K_RANGE, P_END, 8'd0, 32'd0, 1'b0);
      end
    end else if (m == M_IDENT) begin
      tok(s, r, n, K_IDENT, P_END, 8'd0, 32'd0, 1'b0);
    end else if (m == M_REP) begin
      tok(s, r, n, K_REP, P_START, 8'd0, 32'd0, 1'b0);
      if (s.star) begin
        tok(s, r, n, K_REP, P_NUM, 8'd0, s.lo, 1'b0);
        if (s.gempty) tok(s, r, n, K_REP, P_NUM, 8'd0, 32'd0, 1'b1);
        else tok(s, r, n, K_REP, P_NUM, 8'd0, s.acc, 1'b0);
      end else begin
        tok(s, r, n, K_REP, P_NUM, 8'd0, s.acc, 1'b0);
        tok(s, r, n, K_REP, P_NUM, 8'd0, s.acc + 32'd1, 1'b0);
      end
      tok(s, r, n, K_REP, P_END, 8'd0, 32'd0, 1'b0);
    end
  endfunction

  function automatic void begin_number(inout state_t s, input logic [1:0] base);
    s.base = base;
    s.acc = '0;
    s.lo = '0;
    s.gempty = 1'b1;
    s.star = 1'b0;
  endfunction

  // Returns 1 when the character was consumed; 0 asks for another pass.
  function automatic logic step_char(inout state_t s, inout res_arr_t r, inout logic [3:0] n,
                                     input logic [7:0] c, input logic [15:0] pos);
    logic [4:0] d;
    logic       used;
    used = 1'b1;
    d = digval(s.base, c);
    case (s.mode)
      M_IDLE: begin
        s.tstart = pos;
        s.tlen = 16'd1;
        if (c == C_SPACE) begin
        end else if (c == C_QUOTE) begin
          s.sflag = 1'b0;
          tok(s, r, n, K_STR, P_START, 8'd0, 32'd0, 1'b0);
          s.mode = M_STRING;
        end else if (c == C_PCT) begin
          s.mode = M_PCT;
        end else if (c == C_SEMI) begin
          s.mode = M_COMMENT;
        end else if (letter_char(c)) begin
          s.tlen = 16'd0;
          tok(s, r, n, K_IDENT, P_START, 8'd0, 32'd0, 1'b0);
          s.mode = M_IDENT;
          used = 1'b0;
        end else if (c == C_LT) begin
          tok(s, r, n, K_IDENT, P_START, 8'd0, 32'd0, 1'b0);
          s.mode = M_IDENT;
        end else if (c == C_SLASH) begin
          emit(s, r, n, K_ALT, P_END, 8'd0, 32'd0, 1'b0, pos, 16'd1, 4'd0);
        end else if (c == C_LPAR) begin
          emit(s, r, n, K_SOPEN, P_END, 8'd0, 32'd0, 1'b0, pos, 16'd1, 4'd0);
        end else if (c == C_RPAR) begin
          emit(s, r, n, K_SCLOSE, P_END, 8'd0, 32'd0, 1'b0, pos, 16'd1, 4'd0);
        end else if (c == C_LBRK) begin
          emit(s, r, n, K_OOPEN, P_END, 8'd0, 32'd0, 1'b0, pos, 16'd1, 4'd0);
        end else if (c == C_RBRK) begin
          emit(s, r, n, K_OCLOSE, P_END, 8'd0, 32'd0, 1'b0, pos, 16'd1, 4'd0);
        end else if ((c >= "0" && c <= "9") || c == C_STAR) begin
          s.tlen = 16'd0;
          begin_number(s, B_DEC);
          s.mode = M_REP;
          used = 1'b0;
        end else begin
          fail(s, r, n, E_BAD_START, pos, 16'd1);
        end
      end
      M_STRING: begin
        s.tlen = s.tlen + 16'd1;
        if (c == C_BSLASH) begin
          tok(s, r, n, K_STR, P_TEXT, c, 32'd0, 1'b0);
          s.mode = M_ESCAPE;
        end else if (c == C_QUOTE) begin
          tok(s, r, n, K_STR, P_END, 8'd0, 32'd0, 1'b0);
          s.mode = M_IDLE;
        end else begin
          tok(s, r, n, K_STR, P_TEXT, c, 32'd0, 1'b0);
        end
      end
      M_ESCAPE: begin
        s.tlen = s.tlen + 16'd1;
        tok(s, r, n, K_STR, P_TEXT, c, 32'd0, 1'b0);
        s.mode = M_STRING;
      end
      M_PCT: begin
        s.tlen = s.tlen + 16'd1;
        if (c == "b") begin
          begin_number(s, B_BIN);
          s.mode = M_BASE1;
        end else if (c == "d") begin
          begin_number(s, B_DEC);
          s.mode = M_BASE1;
        end else if (c == "x") begin
          begin_number(s, B_HEX);
          s.mode = M_BASE1;
        end else if (c == "s" || c == "i") begin
          s.sflag = (c == "s");
          s.mode = M_FLAG;
        end else begin
          fail(s, r, n, E_AFTER_PCT, pos, 16'd1);
        end
      end
      M_FLAG: begin
        if (c != C_QUOTE) begin
          fail(s, r, n, E_FLAG, s.tstart, 16'd3);
        end else begin
          s.tlen = s.tlen + 16'd1;
          tok(s, r, n, K_STR, P_START, 8'd0, 32'd0, 1'b0);
          s.mode = M_STRING;
        end
      end
      M_BASE1: begin
        if (d[4]) begin
          fail(s, r, n, E_BAD_DIGIT, pos, 16'd1);
        end else begin
          s.mode = M_NUM;
          used = 1'b0;
        end
      end
      M_NUM: begin
        if (!d[4]) begin
          accumulate(s, r, n, d[3:0], pos);
        end else if (c == C_DOT) begin
          if (s.gempty) begin
            fail(s, r, n, E_EMPTY_GROUP, pos, 16'd1);
          end else begin
            if (!s.star) tok(s, r, n, K_NUM, P_START, 8'd0, 32'd0, 1'b0);
            tok(s, r, n, K_NUM, P_NUM, 8'd0, s.acc, 1'b0);
            s.star = 1'b1;
            s.acc = '0;
            s.gempty = 1'b1;
            s.tlen = s.tlen + 16'd1;
          end
        end else if (c == C_DASH && !s.star) begin
          s.lo = s.acc;
          s.acc = '0;
          s.gempty = 1'b1;
          s.mode = M_RANGE;
          s.tlen = s.tlen + 16'd1;
        end else begin
          close_token(s, r, n, pos, 1'b0);
          used = 1'b0;
        end
      end
      M_RANGE: begin
        if (!d[4]) begin
          accumulate(s, r, n, d[3:0], pos);
        end else begin
          close_token(s, r, n, pos, 1'b0);
          used = 1'b0;
        end
      end
      M_IDENT: begin
        if (letter_char(c) || c == C_UNDER || c == C_DASH) begin
          s.tlen = s.tlen + 16'd1;
          tok(s, r, n, K_IDENT, P_TEXT, c, 32'd0, 1'b0);
        end else if (c == C_GT) begin
          s.tlen = s.tlen + 16'd1;
          close_token(s, r, n, pos, 1'b0);
        end else begin
          close_token(s, r, n, pos, 1'b0);
          used = 1'b0;
        end
      end
      M_REP: begin
        if (c >= "0" && c <= "9") begin
          accumulate(s, r, n, c[3:0], pos);
        end else if (c == C_STAR) begin
          if (s.star) begin
            fail(s, r, n, E_STAR2, pos, 16'd1);
          end else begin
            s.lo = s.acc;
            s.acc = '0;
            s.gempty = 1'b1;
            s.star = 1'b1;
            s.tlen = s.tlen + 16'd1;
          end
        end else begin
          close_token(s, r, n, pos, 1'b0);
          used = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return used;
  endfunction

endpackage

// ===== hw/rtl/abnf_if.sv =====
// Handshake channels of the ABNF rule tokenizer: characters in, tokens out.
// Depends on nothing.
interface abnf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       has_char;
  logic       is_last;
  modport source (output valid, in_char, has_char, is_last, input ready);
  modport sink (input valid, in_char, has_char, is_last, output ready);
endinterface

interface abnf_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [1:0]  part;
  logic [7:0]  text_char;
  logic [31:0] number;
  logic        infinite;
  logic        case_sensitive;
  logic [15:0] start_pos;
  logic [15:0] span_len;
  logic [3:0]  error_code;
  logic        last;
  modport source (output valid, token_kind, part, text_char, number, infinite,
                  case_sensitive, start_pos, span_len, error_code, last, input ready);
  modport sink (input valid, token_kind, part, text_char, number, infinite,
                case_sensitive, start_pos, span_len, error_code, last, output ready);
endinterface

// ===== hw/rtl/abnf_step.sv =====
// Lexer step for one accepted character: up to three passes over the mode
// logic, then end-of-rule checks. Uses abnf_pkg.
module abnf_step (
  input  abnf_pkg::state_t   cur,
  input  logic [7:0]         in_char,
  input  logic               has_char,
  input  logic               is_last,
  output abnf_pkg::state_t   nxt,
  output abnf_pkg::res_arr_t res,
  output logic [3:0]         count
);

  always_comb begin
    abnf_pkg::state_t   s;
    abnf_pkg::res_arr_t r;
    logic [3:0]         n;
    logic               done;
    s = cur;
    r = '0;
    n = 4'd0;
    done = 1'b0;
    if (has_char) begin
      // A character that closes a token is seen again by the idle logic.
      for (int i = 0; i < 3; i++) begin
        if (!done && !s.failed) begin
          if (abnf_pkg::step_char(s, r, n, in_char, s.pos)) done = 1'b1;
        end
      end
      s.pos = s.pos + 16'd1;
    end
    if (is_last) begin
      if (!s.failed) begin
        case (s.mode)
          abnf_pkg::M_STRING, abnf_pkg::M_ESCAPE:
            abnf_pkg::fail(s, r, n, abnf_pkg::E_UNTERM, s.tstart, s.tlen);
          abnf_pkg::M_PCT, abnf_pkg::M_FLAG, abnf_pkg::M_BASE1:
            abnf_pkg::fail(s, r, n, abnf_pkg::E_END_PCT, s.tstart, s.tlen);
          abnf_pkg::M_NUM, abnf_pkg::M_RANGE, abnf_pkg::M_IDENT, abnf_pkg::M_REP:
            abnf_pkg::close_token(s, r, n, s.pos, 1'b1);
          default: begin
          end
        endcase
        if (!s.failed && !s.any) abnf_pkg::fail(s, r, n, abnf_pkg::E_EMPTY_RULE, s.pos, 16'd0);
      end
      s = abnf_pkg::reset_state();
    end
    if (n != 4'd0) r[3'(n - 4'd1)].last = 1'b1;
    nxt = s;
    res = r;
    count = n;
  end

endmodule

// ===== hw/rtl/abnf_rbuf.sv =====
// Result buffer: holds one character's burst and hands it out one transfer
// per cycle while the sink is ready. Uses abnf_pkg and abnf_token_if.
module abnf_rbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  abnf_pkg::res_arr_t load_res,
  input  logic [3:0]         load_count,
  output logic               can_load,
  abnf_token_if.source       tokens
);

  abnf_pkg::res_arr_t store;
  logic [3:0]         count;
  logic [2:0]         idx;
  abnf_pkg::res_t     head;
  logic               pop;

  assign pop = tokens.valid && tokens.ready;
  assign can_load = (count == 4'd0) || (count == 4'd1 && tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
      idx <= 3'd0;
    end else if (load) begin
      count <= load_count;
      idx <= 3'd0;
    end else if (pop) begin
      count <= count - 4'd1;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) store <= load_res;
  end

  assign head = store[idx];
  assign tokens.valid = (count != 4'd0);
  assign tokens.token_kind = head.token_kind;
  assign tokens.part = head.part;
  assign tokens.text_char = head.text_char;
  assign tokens.number = head.number;
  assign tokens.infinite = head.infinite;
  assign tokens.case_sensitive = head.case_sensitive;
  assign tokens.start_pos = head.start_pos;
  assign tokens.span_len = head.span_len;
  assign tokens.error_code = head.error_code;
  assign tokens.last = head.last;

endmodule

// ===== hw/rtl/abnf_rule_tokenizer_unit.sv =====
// Top level of the ABNF rule tokenizer: lexer state register, step logic
// and result buffer. Uses abnf_pkg, abnf_if, abnf_step and abnf_rbuf.
//
// Characters of one ABNF rule arrive one transfer at a time; each one updates
// the lexer state and writes the tokens it completes (up to eight results)
// into the result buffer, which sends one result per cycle while the receiver
// is ready. A character that causes at most one result is then taken every
// cycle; one that causes more holds the input while the buffer drains, so the
// buffer's single output port sets the rate. The last result of each character
// carries last. After is_last the lexer returns to its reset state.
module abnf_rule_tokenizer_unit (
  input logic          clk,
  input logic          rst,
  abnf_char_if.sink    chars,
  abnf_token_if.source tokens
);

  abnf_pkg::state_t   state;
  abnf_pkg::state_t   state_next;
  abnf_pkg::res_arr_t res;
  logic [3:0]         res_count;
  logic               can_load;
  logic               take;

  assign chars.ready = can_load;
  assign take = chars.valid && can_load;

  abnf_step u_step (
    .cur      (state),
    .in_char  (chars.in_char),
    .has_char (chars.has_char),
    .is_last  (chars.is_last),
    .nxt      (state_next),
    .res      (res),
    .count    (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abnf_pkg::reset_state();
    end else if (take) begin
      state <= state_next;
    end
  end

  abnf_rbuf u_rbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_res   (res),
    .load_count (res_count),
    .can_load   (can_load),
    .tokens     (tokens)
  );

endmodule
